@@ hw/rtl/emdc_pkg.sv @@
`timescale 1ns / 1ps

package emdc_pkg;

  // Direction codes carried in the mode field.
  localparam logic ModeToEpoch = 1'b0;
  localparam logic ModeToDate  = 1'b1;

  // Calendar limits of the supported range.
  localparam logic [11:0] FirstYear = 12'd1970;
  localparam logic [11:0] MinYear   = 12'd2000;
  localparam logic [11:0] MaxYear   = 12'd2099;

  // First millisecond of 2100-01-01; epochs at or past it are rejected.
  localparam logic [63:0] EpochLimitMs = 64'd4102444800000;

  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [16:0] SecPerMin  = 17'd60;
  localparam logic [16:0] MsPerSec   = 17'd1000;

  // Width of the millisecond datapath of the shared subtract unit.
  localparam int unsigned DivDataW = 42;

  // Step sizes, in milliseconds, that the epoch-to-date walk subtracts.
  localparam logic [DivDataW-1:0] SecMs      = 42'd1000;
  localparam logic [DivDataW-1:0] MinMs      = 42'd60000;
  localparam logic [DivDataW-1:0] HourMs     = 42'd3600000;
  localparam logic [DivDataW-1:0] DayMs      = 42'd86400000;
  localparam logic [DivDataW-1:0] YearMs     = 42'd365 * DayMs;
  localparam logic [DivDataW-1:0] LeapYearMs = 42'd366 * DayMs;

  typedef struct packed {
    logic        mode;
    logic [63:0] epoch_in;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } in_item_t;

  typedef struct packed {
    logic [41:0] epoch_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        valid_res;
  } out_item_t;

  // Operands of and answer from the shared compare-and-subtract unit.
  typedef struct packed {
    logic [DivDataW-1:0] minuend;
    logic [DivDataW-1:0] step;
  } div_req_t;

  typedef struct packed {
    logic                fits;
    logic [DivDataW-1:0] diff;
  } div_rsp_t;

  // Leap rule for the years the block ever visits (1970 to 2099): inside
  // that span the century exceptions never apply, and 2000 is a leap year.
  function automatic logic is_leap(input logic [11:0] yr);
    return (yr[1:0] == 2'b00);
  endfunction

  function automatic logic [8:0] year_days(input logic [11:0] yr);
    return is_leap(yr) ? 9'd366 : 9'd365;
  endfunction

  // Length of a month; a month code outside 1 to 12 has no days.
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Milliseconds in a month of the given length in days.
  function automatic logic [DivDataW-1:0] month_ms(input logic [4:0] len);
    logic [DivDataW-1:0] ms;
    unique case (len)
      5'd28:   ms = 42'd28 * DayMs;
      5'd29:   ms = 42'd29 * DayMs;
      5'd30:   ms = 42'd30 * DayMs;
      5'd31:   ms = 42'd31 * DayMs;
      default: ms = '0;
    endcase
    return ms;
  endfunction

endpackage

@@ hw/rtl/emdc_div.sv @@
`timescale 1ns / 1ps

// Shared compare-and-subtract step: tells whether the step still fits into
// the running remainder and gives the remainder after taking it away.
module emdc_div (
  input  emdc_pkg::div_req_t req_i,
  output emdc_pkg::div_rsp_t rsp_o
);

  logic [emdc_pkg::DivDataW:0] diff;

  // The extra top bit is the borrow; it is set when the step does not fit.
  assign diff = {1'b0, req_i.minuend} - {1'b0, req_i.step};

  assign rsp_o.fits = !diff[emdc_pkg::DivDataW];
  assign rsp_o.diff = diff[emdc_pkg::DivDataW-1:0];

endmodule

@@ hw/rtl/epoch_ms_date_converter.sv @@
`timescale 1ns / 1ps

// Converts between a civil date-time (years 2000 to 2099) and milliseconds
// since 1970-01-01 00:00:00, one item at a time; mode 0 goes from date to
// milliseconds and mode 1 back. A date-to-epoch item counts days over each
// year since 1970 and each month before the given one, then runs the
// multiply chain (days, hours, minutes and seconds, then milliseconds) and
// loads the result. An epoch-to-date item walks the milliseconds down with
// one shared compare-and-subtract unit, taking away whole years, months,
// days, hours, minutes and seconds in turn at one step a cycle. Invalid
// dates and epochs at or past 2100 go straight to the done state and give
// all-zero results. The input stalls while an item is in work; a finished
// result waits in the output register, and the next item may be taken
// meanwhile. A result that finds the output register still held waits
// until it is taken.
module epoch_ms_date_converter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  emdc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output emdc_pkg::out_item_t  out_item_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StYear0   = 4'd1;
  localparam logic [3:0] StMonth0  = 4'd2;
  localparam logic [3:0] StMulDay  = 4'd3;
  localparam logic [3:0] StMulHour = 4'd4;
  localparam logic [3:0] StMulMin  = 4'd5;
  localparam logic [3:0] StMulMs   = 4'd6;
  localparam logic [3:0] StYear1   = 4'd7;
  localparam logic [3:0] StMonth1  = 4'd8;
  localparam logic [3:0] StDay1    = 4'd9;
  localparam logic [3:0] StHour1   = 4'd10;
  localparam logic [3:0] StMin1    = 4'd11;
  localparam logic [3:0] StSec1    = 4'd12;
  localparam logic [3:0] StDone    = 4'd13;

  logic [3:0]  state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        mode_q, mode_d;
  logic        zero_q, zero_d;
  logic [11:0] ytgt_q, ytgt_d;
  logic [3:0]  mtgt_q, mtgt_d;
  logic [4:0]  dtgt_q, dtgt_d;
  logic [11:0] yr_q, yr_d;
  logic [3:0]  mon_q, mon_d;
  logic [15:0] days_q, days_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  mi_q, mi_d;
  logic [5:0]  se_q, se_d;
  logic [31:0] acc_q, acc_d;
  logic [41:0] epoch_q, epoch_d;
  logic [41:0] rem_q, rem_d;
  emdc_pkg::out_item_t out_q, out_d;

  emdc_pkg::div_req_t div_req;
  emdc_pkg::div_rsp_t div_rsp;

  logic       in_fire;
  logic       date_ok;
  logic       epoch_over;
  logic [4:0] mlen;
  logic [8:0] ylen;

  emdc_div u_div (
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Range check of an incoming date, used in mode 0 only.
  assign date_ok = (in_item_i.year_in >= emdc_pkg::MinYear) &&
                   (in_item_i.year_in <= emdc_pkg::MaxYear) &&
                   (in_item_i.day_in != 5'd0) &&
                   (in_item_i.day_in <= emdc_pkg::month_days(
                      emdc_pkg::is_leap(in_item_i.year_in), in_item_i.month_in)) &&
                   (in_item_i.hour_in <= 5'd23) &&
                   (in_item_i.minute_in <= 6'd59) &&
                   (in_item_i.second_in <= 6'd59);

  assign epoch_over = (in_item_i.epoch_in >= emdc_pkg::EpochLimitMs);

  // Length of the year and month the loops are currently stepping over.
  assign ylen = emdc_pkg::year_days(yr_q);
  assign mlen = emdc_pkg::month_days(
                  emdc_pkg::is_leap((mode_q == emdc_pkg::ModeToDate) ? yr_q : ytgt_q),
                  mon_q);

  // Step that the shared unit tries to take from the remainder.
  always_comb begin
    div_req.minuend = rem_q;
    unique case (state_q)
      StYear1:  div_req.step = emdc_pkg::is_leap(yr_q) ? emdc_pkg::LeapYearMs
                                                       : emdc_pkg::YearMs;
      StMonth1: div_req.step = emdc_pkg::month_ms(mlen);
      StDay1:   div_req.step = emdc_pkg::DayMs;
      StHour1:  div_req.step = emdc_pkg::HourMs;
      StMin1:   div_req.step = emdc_pkg::MinMs;
      default:  div_req.step = emdc_pkg::SecMs;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mode_d      = mode_q;
    zero_d      = zero_q;
    ytgt_d      = ytgt_q;
    mtgt_d      = mtgt_q;
    dtgt_d      = dtgt_q;
    yr_d        = yr_q;
    mon_d       = mon_q;
    days_d      = days_q;
    hr_d        = hr_q;
    mi_d        = mi_q;
    se_d        = se_q;
    acc_d       = acc_q;
    epoch_d     = epoch_q;
    rem_d       = rem_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          mode_d = in_item_i.mode;
          ytgt_d = in_item_i.year_in;
          mtgt_d = in_item_i.month_in;
          dtgt_d = in_item_i.day_in;
          yr_d   = emdc_pkg::FirstYear;
          mon_d  = 4'd1;
          days_d = '0;
          if (in_item_i.mode == emdc_pkg::ModeToEpoch) begin
            hr_d    = in_item_i.hour_in;
            mi_d    = in_item_i.minute_in;
            se_d    = in_item_i.second_in;
            zero_d  = !date_ok;
            state_d = date_ok ? StYear0 : StDone;
          end else begin
            hr_d    = '0;
            mi_d    = '0;
            se_d    = '0;
            rem_d   = in_item_i.epoch_in[41:0];
            zero_d  = epoch_over;
            state_d = epoch_over ? StDone : StYear1;
          end
        end
      end

      // Date to epoch: count whole years, then whole months, then days.
      StYear0: begin
        if (yr_q < ytgt_q) begin
          days_d = days_q + 16'(ylen);
          yr_d   = yr_q + 1'b1;
        end else begin
          state_d = StMonth0;
        end
      end

      StMonth0: begin
        if (mon_q < mtgt_q) begin
          days_d = days_q + 16'(mlen);
          mon_d  = mon_q + 1'b1;
        end else begin
          days_d  = days_q + 16'(dtgt_q - 5'd1);
          state_d = StMulDay;
        end
      end

      StMulDay: begin
        acc_d   = 32'(days_q) * 32'(emdc_pkg::SecPerDay);
        state_d = StMulHour;
      end

      StMulHour: begin
        acc_d   = acc_q + 32'(hr_q) * 32'(emdc_pkg::SecPerHour);
        state_d = StMulMin;
      end

      StMulMin: begin
        acc_d   = acc_q + 32'(mi_q) * 32'(emdc_pkg::SecPerMin) + 32'(se_q);
        state_d = StMulMs;
      end

      StMulMs: begin
        epoch_d = 42'(acc_q) * 42'(emdc_pkg::MsPerSec);
        state_d = StDone;
      end

      // Epoch to date: take away whole years, then months, days, hours,
      // minutes and seconds; the leftover milliseconds are dropped.
      StYear1: begin
        if (div_rsp.fits) begin
          rem_d = div_rsp.diff;
          yr_d  = yr_q + 1'b1;
        end else begin
          state_d = StMonth1;
        end
      end

      StMonth1: begin
        if ((mon_q <= 4'd12) && div_rsp.fits) begin
          rem_d = div_rsp.diff;
          mon_d = mon_q + 1'b1;
        end else begin
          state_d = StDay1;
        end
      end

      StDay1: begin
        if (div_rsp.fits) begin
          rem_d  = div_rsp.diff;
          days_d = days_q + 16'd1;
        end else begin
          state_d = StHour1;
        end
      end

      StHour1: begin
        if (div_rsp.fits) begin
          rem_d = div_rsp.diff;
          hr_d  = hr_q + 5'd1;
        end else begin
          state_d = StMin1;
        end
      end

      StMin1: begin
        if (div_rsp.fits) begin
          rem_d = div_rsp.diff;
          mi_d  = mi_q + 6'd1;
        end else begin
          state_d = StSec1;
        end
      end

      StSec1: begin
        if (div_rsp.fits) begin
          rem_d = div_rsp.diff;
          se_d  = se_q + 6'd1;
        end else begin
          state_d = StDone;
        end
      end

      // Hand the result to the output register once it is free.
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = '0;
          if (!zero_q) begin
            if (mode_q == emdc_pkg::ModeToEpoch) begin
              out_d.epoch_out = epoch_q;
              out_d.valid_res = 1'b1;
            end else begin
              out_d.year_out   = yr_q;
              out_d.month_out  = mon_q;
              out_d.day_out    = 5'(days_q + 16'd1);
              out_d.hour_out   = hr_q;
              out_d.minute_out = mi_q;
              out_d.second_out = se_q;
              out_d.valid_res  = (yr_q >= emdc_pkg::MinYear);
            end
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    mode_q   <= mode_d;
    zero_q   <= zero_d;
    ytgt_q   <= ytgt_d;
    mtgt_q   <= mtgt_d;
    dtgt_q   <= dtgt_d;
    yr_q     <= yr_d;
    mon_q    <= mon_d;
    days_q   <= days_d;
    hr_q     <= hr_d;
    mi_q     <= mi_d;
    se_q     <= se_d;
    acc_q    <= acc_d;
    epoch_q  <= epoch_d;
    rem_q    <= rem_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
